FILE: design/rrls_pkg.sv
// Package for the round-robin lock scheduler: sizes, command, opcode,
// status and configuration register codes, and shared types.
// No dependencies.
package rrls_pkg;
    localparam int NUM_PROGS = 16;
    localparam int NUM_STMTS = 1024;
    localparam int NUM_VARS  = 26;
    localparam int PW = $clog2(NUM_PROGS);
    localparam int SW = $clog2(NUM_STMTS);

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    localparam logic [1:0] OP_ASSIGN = 2'd0;
    localparam logic [1:0] OP_PRINT  = 2'd1;
    localparam logic [1:0] OP_LOCK   = 2'd2;
    localparam logic [1:0] OP_UNLOCK = 2'd3;

    localparam logic [1:0] ST_RAN     = 2'd0;
    localparam logic [1:0] ST_PRINTED = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_IDLE    = 2'd3;

    localparam logic [2:0] REG_COST_ASSIGN = 3'd0;
    localparam logic [2:0] REG_COST_PRINT  = 3'd1;
    localparam logic [2:0] REG_COST_LOCK   = 3'd2;
    localparam logic [2:0] REG_COST_UNLOCK = 3'd3;
    localparam logic [2:0] REG_QUANTUM     = 3'd4;

    typedef struct packed {
        logic [15:0] value;
        logic [4:0]  var_idx;
        logic [1:0]  opcode;
    } t_stmt;

    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [15:0] wdata;
    } t_var_wr;
endpackage

FILE: design/rrls_stmt_ram.sv
// Single-port statement memory with registered read data.
// Generic; used by the scheduler top level.
module rrls_stmt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 23
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: design/rrls_var_file.sv
// Variable file a..z, cleared at reset, one write and one read port.
// Depends on rrls_pkg.
module rrls_var_file
    import rrls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_var_wr     i_wr,
    input  logic [4:0]  i_raddr,
    output logic [15:0] o_rdata
);
    logic [15:0] r_vars [NUM_VARS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VARS; i++) r_vars[i] <= '0;
        end else if (i_wr.we && i_wr.addr < 5'(NUM_VARS)) begin
            r_vars[i_wr.addr] <= i_wr.wdata;
        end
    end

    // Indexes beyond z print as zero.
    assign o_rdata = (i_raddr < 5'(NUM_VARS)) ? r_vars[i_raddr] : 16'd0;
endmodule

FILE: design/round_robin_lock_scheduler_top.sv
// Round-robin lock scheduler top level: control sequencer, queues and tables.
// Depends on rrls_pkg, rrls_stmt_ram and rrls_var_file.
//
// Load and close transactions produce no result. A step with a program
// running reads statement memory, then executes; otherwise it first pops
// ready-queue entries while scheduling, then reads and executes. A step with
// nothing runnable answers in the cycle after it is accepted when the ready
// queue is empty; otherwise it first drops each empty program from it. The result
// strobe o_valid is high for one cycle and cannot be stalled. busy is high
// while a step is in progress; start is ignored then.
module round_robin_lock_scheduler_top
    import rrls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [1:0]  i_opcode,
    input  logic [4:0]  i_variable,
    input  logic [15:0] i_value,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [4:0]  o_program_id,
    output logic [15:0] o_print_value
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCHED = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0]    r_state;
    logic [7:0]    r_cost [4];
    logic [15:0]   r_quantum;
    logic [SW:0]   r_stored;
    logic [PW:0]   r_prog_cnt;
    logic [SW:0]   r_prog_start;
    logic [SW:0]   r_next [NUM_PROGS];
    logic [SW:0]   r_end  [NUM_PROGS];
    logic [PW-1:0] r_rdy_ring [NUM_PROGS];
    logic [PW-1:0] r_rdy_head;
    logic [PW:0]   r_rdy_size;
    logic [PW-1:0] r_blk_ring [NUM_PROGS];
    logic [PW-1:0] r_blk_head;
    logic [PW:0]   r_blk_size;
    logic          r_lock;
    logic          r_run;
    logic [PW-1:0] r_prog;
    logic [15:0]   r_time;

    logic          accept;
    logic          mem_we;
    logic [SW-1:0] mem_addr;
    t_stmt         mem_rdata;
    t_stmt         wr_stmt;
    t_var_wr       var_wr;
    logic [15:0]   var_rdata;
    logic [PW-1:0] pick;
    logic [7:0]    cost;
    logic [15:0]   time_nx;
    logic [SW:0]   next_inc;
    logic          unlock_wake;
    logic [PW:0]   rdy_after_wake;
    logic          requeue;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign mem_we = accept && i_command == CMD_LOAD && !r_stored[SW] && !r_prog_cnt[PW];
    assign mem_addr = mem_we ? r_stored[SW-1:0] : r_next[r_prog][SW-1:0];
    assign wr_stmt  = '{value: i_value, var_idx: i_variable, opcode: i_opcode};

    rrls_stmt_ram #(.DEPTH(NUM_STMTS), .WIDTH($bits(t_stmt))) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (wr_stmt),
        .o_rdata (mem_rdata)
    );

    assign var_wr = '{we: r_state == S_EXEC && mem_rdata.opcode == OP_ASSIGN,
                      addr: mem_rdata.var_idx, wdata: mem_rdata.value};

    rrls_var_file u_vars (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (var_wr),
        .i_raddr (mem_rdata.var_idx),
        .o_rdata (var_rdata)
    );

    assign pick     = r_rdy_ring[r_rdy_head];
    assign cost     = r_cost[mem_rdata.opcode];
    assign time_nx  = ({8'd0, cost} >= r_time) ? 16'd0 : r_time - {8'd0, cost};
    assign next_inc = r_next[r_prog] + 1'b1;

    // An unlock hands the blocked head to the front of the ready queue; an expired
    // slice then goes behind everything already queued.
    assign unlock_wake    = mem_rdata.opcode == OP_UNLOCK && r_blk_size != '0 &&
                            !r_rdy_size[PW];
    assign rdy_after_wake = r_rdy_size + (PW+1)'(unlock_wake);
    assign requeue        = next_inc < r_end[r_prog] && time_nx == '0 &&
                            !rdy_after_wake[PW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            for (int i = 0; i < 4; i++) r_cost[i] <= 8'd1;
            r_quantum    <= 16'd1;
            r_stored     <= '0;
            r_prog_cnt   <= '0;
            r_prog_start <= '0;
            r_rdy_head   <= '0;
            r_rdy_size   <= '0;
            r_blk_head   <= '0;
            r_blk_size   <= '0;
            r_lock       <= 1'b0;
            r_run        <= 1'b0;
            r_prog       <= '0;
            r_time       <= '0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_COST_ASSIGN: r_cost[OP_ASSIGN] <= i_cfg_data[7:0];
                    REG_COST_PRINT:  r_cost[OP_PRINT]  <= i_cfg_data[7:0];
                    REG_COST_LOCK:   r_cost[OP_LOCK]   <= i_cfg_data[7:0];
                    REG_COST_UNLOCK: r_cost[OP_UNLOCK] <= i_cfg_data[7:0];
                    REG_QUANTUM:     r_quantum         <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (mem_we) begin
                            r_stored <= r_stored + 1'b1;
                        end
                        if (i_command == CMD_CLOSE && !r_prog_cnt[PW]) begin
                            r_next[r_prog_cnt[PW-1:0]] <= r_prog_start;
                            r_end[r_prog_cnt[PW-1:0]]  <= r_stored;
                            r_prog_start <= r_stored;
                            if (!r_rdy_size[PW]) begin
                                r_rdy_ring[r_rdy_head + r_rdy_size[PW-1:0]] <=
                                    r_prog_cnt[PW-1:0];
                                r_rdy_size <= r_rdy_size + 1'b1;
                            end
                            r_prog_cnt <= r_prog_cnt + 1'b1;
                        end
                        if (i_command == CMD_STEP) begin
                            if (r_run) begin
                                r_state <= S_READ;
                            end else if (r_rdy_size != '0) begin
                                r_state <= S_SCHED;
                            end else begin
                                o_valid       <= 1'b1;
                                o_status      <= ST_IDLE;
                                o_program_id  <= '0;
                                o_print_value <= '0;
                            end
                        end
                    end
                end
                S_SCHED: begin
                    // Pop one ready entry per cycle; empty programs are dropped.
                    r_rdy_head <= r_rdy_head + 1'b1;
                    r_rdy_size <= r_rdy_size - 1'b1;
                    if (r_next[pick] < r_end[pick]) begin
                        r_run   <= 1'b1;
                        r_prog  <= pick;
                        r_time  <= (r_quantum == '0) ? 16'd1 : r_quantum;
                        r_state <= S_READ;
                    end else if (r_rdy_size == (PW+1)'(1)) begin
                        o_valid       <= 1'b1;
                        o_status      <= ST_IDLE;
                        o_program_id  <= '0;
                        o_print_value <= '0;
                        r_state       <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state       <= S_IDLE;
                    o_valid       <= 1'b1;
                    o_program_id  <= 5'(r_prog) + 5'd1;
                    if (mem_rdata.opcode == OP_LOCK && r_lock) begin
                        // Held lock: park the program without consuming the statement.
                        if (!r_blk_size[PW]) begin
                            r_blk_ring[r_blk_head + r_blk_size[PW-1:0]] <= r_prog;
                            r_blk_size <= r_blk_size + 1'b1;
                        end
                        r_run         <= 1'b0;
                        o_status      <= ST_BLOCKED;
                        o_print_value <= '0;
                    end else begin
                        if (mem_rdata.opcode == OP_PRINT) begin
                            o_status      <= ST_PRINTED;
                            o_print_value <= var_rdata;
                        end else begin
                            o_status      <= ST_RAN;
                            o_print_value <= '0;
                        end
                        if (mem_rdata.opcode == OP_LOCK) r_lock <= 1'b1;
                        if (mem_rdata.opcode == OP_UNLOCK) begin
                            r_lock <= 1'b0;
                            if (r_blk_size != '0) begin
                                r_blk_head <= r_blk_head + 1'b1;
                                r_blk_size <= r_blk_size - 1'b1;
                            end
                        end
                        if (unlock_wake) begin
                            r_rdy_head <= r_rdy_head - 1'b1;
                            r_rdy_ring[r_rdy_head - 1'b1] <= r_blk_ring[r_blk_head];
                        end
                        if (requeue) begin
                            r_rdy_ring[r_rdy_head + r_rdy_size[PW-1:0]] <= r_prog;
                        end
                        r_rdy_size     <= rdy_after_wake + (PW+1)'(requeue);
                        r_time         <= time_nx;
                        r_next[r_prog] <= next_inc;
                        if (next_inc >= r_end[r_prog] || time_nx == '0) begin
                            r_run <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_rdy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdy_size[PW] |-> r_rdy_size[PW-1:0] == '0)
        else $error("ready queue size beyond capacity");
    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_IDLE |-> o_program_id == '0)
        else $error("idle result carries a program number");
    a_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_PRINTED |-> o_print_value == '0)
        else $error("print value set on a non-print result");
    a_exec_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_run)
        else $error("statement read without a running program");
`endif
endmodule
